>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL files; spsr_ctrl is the one that includes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/spsr_pkg.sv
// ----------------------------------------------------------------------------
// spsr_pkg
// Types, constants and coil tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
package spsr_pkg;

  localparam int MAX_STEPS    = 4096;
  localparam int PERIOD_SCALE = 3000;
  localparam int FAST_LIMIT   = 100;

  localparam int STEPS_W  = 13;
  localparam int MODE_W   = 2;
  localparam int FUNC_W   = 2;
  localparam int SPEED_W  = 16;
  localparam int POS_W    = 13;
  localparam int PERIOD_W = 24;
  localparam int COIL_W   = 4;
  localparam int REG_W    = 1;

  // effective step count, clamped to 1..MAX_STEPS
  localparam int EFF_W   = $clog2(MAX_STEPS + 1);
  localparam int LIM_W   = EFF_W + 1;
  localparam int SCALE_W = $clog2(PERIOD_SCALE + 1);
  localparam int PROD_W  = $clog2(MAX_STEPS * PERIOD_SCALE + 1);
  localparam int DIV_W   = (PROD_W > PERIOD_W) ? PROD_W : PERIOD_W;
  localparam int CNT_W   = $clog2(DIV_W);

  localparam logic [STEPS_W-1:0]  STEPS_RESET = STEPS_W'(200);
  localparam logic [PERIOD_W-1:0] IDLE_PERIOD = PERIOD_W'(8000);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;

  localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RAMP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TARGET = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WAVE = 2'd2;

  localparam logic [REG_W-1:0] REG_STEPS = 1'b0;
  localparam logic [REG_W-1:0] REG_MODE  = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [SPEED_W-1:0] target_speed;
  } cmd_t;

  typedef struct packed {
    logic [COIL_W-1:0]         coils;
    logic [POS_W-1:0]          position;
    logic signed [SPEED_W-1:0] speed_now;
    logic [PERIOD_W-1:0]       step_period;
    logic                      rearm;
  } res_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul;
    logic div_step;
    logic wb;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

  function automatic logic [COIL_W-1:0] full_coil(input logic [1:0] i);
    logic [COIL_W-1:0] c;
    unique case (i)
      2'd0: c = 4'hA;
      2'd1: c = 4'h6;
      2'd2: c = 4'h5;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  function automatic logic [COIL_W-1:0] half_coil(input logic [2:0] i);
    logic [COIL_W-1:0] c;
    unique case (i)
      3'd0: c = 4'h9;
      3'd1: c = 4'h8;
      3'd2: c = 4'hA;
      3'd3: c = 4'h2;
      3'd4: c = 4'h6;
      3'd5: c = 4'h4;
      3'd6: c = 4'h5;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

  function automatic logic [COIL_W-1:0] wave_coil(input logic [1:0] i);
    logic [COIL_W-1:0] c;
    unique case (i)
      2'd0: c = 4'h8;
      2'd1: c = 4'h2;
      2'd2: c = 4'h4;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/spsr_dp.sv
// ----------------------------------------------------------------------------
// spsr_dp
// Datapath: config registers, motor state, period divider, result register.
// ----------------------------------------------------------------------------
module spsr_dp
  import spsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [REG_W-1:0]   wr_index,
  input  logic [STEPS_W-1:0] wr_data,
  input  cmd_t               cmd,
  input  ctl_t               ctl,
  output stat_t              stat,
  output res_t               res
);

  logic [STEPS_W-1:0]        steps_per_rev;
  logic [MODE_W-1:0]         drive_mode;
  logic [FUNC_W-1:0]         func_q;
  logic signed [SPEED_W-1:0] tgt_q;

  logic [POS_W-1:0]          step_index;
  logic signed [SPEED_W-1:0] cur_speed;
  logic signed [SPEED_W-1:0] goal_speed;
  logic [PERIOD_W-1:0]       period_ticks;
  logic [COIL_W-1:0]         coil_pattern;
  logic                      rearm;

  logic [DIV_W-1:0]          div_quo;
  logic [SPEED_W-1:0]        div_rem;
  logic [SPEED_W-1:0]        div_mag;

  logic [EFF_W-1:0]          eff_steps;
  logic [LIM_W-1:0]          limit;
  logic [LIM_W-1:0]          idx_ext;
  logic [POS_W-1:0]          step_index_next;
  logic [COIL_W-1:0]         coil_pattern_next;
  logic                      speed_set;
  logic signed [SPEED_W-1:0] speed_val;
  logic                      fast;
  logic [SPEED_W-1:0]        speed_mag;
  logic [SPEED_W:0]          rem_sh;
  logic [SPEED_W:0]          rem_diff;
  logic                      rem_ge;

  always_comb begin
    logic [31:0] s;
    s = 32'(steps_per_rev);
    if (s == 32'd0) begin
      s = 32'd1;
    end
    if (s > 32'(MAX_STEPS)) begin
      s = 32'(MAX_STEPS);
    end
    eff_steps = EFF_W'(s);
  end

  // position update for a step tick
  always_comb begin
    limit   = (drive_mode == MODE_HALF) ? {eff_steps, 1'b0} : {1'b0, eff_steps};
    idx_ext = LIM_W'(step_index);
    step_index_next   = step_index;
    coil_pattern_next = coil_pattern;
    if (cur_speed == '0) begin
      coil_pattern_next = '0;
    end else begin
      if (!cur_speed[SPEED_W-1]) begin
        if (idx_ext + LIM_W'(1) >= limit) begin
          step_index_next = '0;
        end else begin
          step_index_next = step_index + POS_W'(1);
        end
      end else begin
        if (step_index == '0 || idx_ext >= limit) begin
          step_index_next = POS_W'(limit - LIM_W'(1));
        end else begin
          step_index_next = step_index - POS_W'(1);
        end
      end
      unique case (drive_mode)
        MODE_FULL: coil_pattern_next = full_coil(step_index_next[1:0]);
        MODE_HALF: coil_pattern_next = half_coil(step_index_next[2:0]);
        MODE_WAVE: coil_pattern_next = wave_coil(step_index_next[1:0]);
        default:   coil_pattern_next = coil_pattern;  // reserved mode holds
      endcase
    end
  end

  // speed update for ramp and target commands
  always_comb begin
    fast = !(cur_speed > -SPEED_W'(FAST_LIMIT) && cur_speed < SPEED_W'(FAST_LIMIT));
    speed_set = 1'b0;
    speed_val = cur_speed;
    unique case (func_q)
      FUNC_RAMP: begin
        if (cur_speed < goal_speed) begin
          speed_set = 1'b1;
          speed_val = cur_speed + SPEED_W'(1);
        end else if (cur_speed > goal_speed) begin
          speed_set = 1'b1;
          speed_val = cur_speed - SPEED_W'(1);
        end
      end
      FUNC_TARGET: begin
        if (!fast) begin
          speed_set = 1'b1;
          speed_val = tgt_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.need_div = speed_set && (speed_val != '0);

  // divider step, one quotient bit a cycle
  assign speed_mag = cur_speed[SPEED_W-1] ? $unsigned(-cur_speed) : $unsigned(cur_speed);
  assign rem_sh    = {div_rem, div_quo[DIV_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, div_mag};
  assign rem_diff  = rem_sh - {1'b0, div_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev <= STEPS_RESET;
      drive_mode    <= MODE_FULL;
    end else if (wr_en) begin
      if (wr_index == REG_STEPS) begin
        steps_per_rev <= wr_data;
      end else begin
        drive_mode <= wr_data[MODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      func_q <= cmd.func;
      tgt_q  <= cmd.target_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index   <= '0;
      cur_speed    <= '0;
      goal_speed   <= '0;
      period_ticks <= IDLE_PERIOD;
      coil_pattern <= '0;
      rearm        <= 1'b0;
    end else begin
      if (ctl.exec) begin
        rearm <= stat.need_div;
        if (func_q == FUNC_STEP) begin
          step_index   <= step_index_next;
          coil_pattern <= coil_pattern_next;
        end
        if (func_q == FUNC_TARGET) begin
          goal_speed <= tgt_q;
        end
        if (speed_set) begin
          cur_speed <= speed_val;
          if (speed_val == '0) begin
            period_ticks <= IDLE_PERIOD;
          end
        end
      end
      if (ctl.wb) begin
        period_ticks <= (div_quo > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                       : div_quo[PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      div_quo <= DIV_W'(eff_steps * SCALE_W'(PERIOD_SCALE));
      div_rem <= '0;
      div_mag <= speed_mag;
    end else if (ctl.div_step) begin
      div_rem <= rem_ge ? rem_diff[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
      div_quo <= {div_quo[DIV_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res.coils       <= coil_pattern;
      res.position    <= step_index;
      res.speed_now   <= cur_speed;
      res.step_period <= period_ticks;
      res.rearm       <= rearm;
    end
  end

endmodule

>>> hw/rtl/spsr_ctrl.sv
// ----------------------------------------------------------------------------
// spsr_ctrl
// Sequencer: accept, execute, period division, result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spsr_ctrl
  import spsr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  output logic  res_valid,
  input  logic  res_stall,
  input  stat_t stat,
  output ctl_t  ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WB   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  div_cnt, div_cnt_next;
  logic              out_free;

  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    ctl          = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = stat.need_div ? S_MUL : S_OUT;
      end
      S_MUL: begin
        ctl.mul      = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (div_cnt == CNT_LAST) begin
          state_next = S_WB;
        end else begin
          div_cnt_next = div_cnt + CNT_W'(1);
        end
      end
      S_WB: begin
        ctl.wb     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      if (ctl.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_accept_exec, clk, rst, (cmd_valid && !cmd_stall) |=> (state == S_EXEC), "accepted transfer not executed")
  `ASSERT_CLK(a_div_len, clk, rst, (state == S_DIV && div_cnt == CNT_LAST) |=> (state == S_WB), "divider ran past its last bit")
  `ASSERT_CLK(a_out_hold, clk, rst, (state == S_OUT && res_valid && res_stall) |=> (state == S_OUT && res_valid), "pending result overwritten")
  `ASSERT_NEVER(a_div_idle, clk, rst, (state == S_MUL && !$past(state == S_EXEC)), "division started without a speed change")

endmodule

>>> hw/rtl/stepper_phase_sequencer_ramp.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_ramp
// Four-coil stepper sequencer with speed ramp and step period calculation.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid / cmd_stall / cmd) carries step ticks, ramp ticks
// and target speed updates; every command gives exactly one result on the
// result channel (res_valid / res_stall / res) with the coil pattern,
// position, speed, step period and the timer rearm flag.
// Registers are written through wr_en / wr_index / wr_data; the user must write
// them only while idle, which the block itself does not enforce: index 0 steps per
// revolution, index 1 drive mode.
// Flow: a command that leaves the speed unchanged or zero passes through the
// execute and output states; one that sets a nonzero speed also passes through
// a multiply, a 24-step restoring divider (one quotient bit per cycle) and a
// write-back before the output state. One command is in flight at a time.
// A held result sits in the output register while the next command is taken;
// the following result waits until that one has been transferred.
// Reset (synchronous, rst high) sets 200 steps, full-step mode, position and
// speeds zero, coils off and the period to 8000.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_ramp
  import spsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_t               cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  input  logic               wr_en,
  input  logic [REG_W-1:0]   wr_index,
  input  logic [STEPS_W-1:0] wr_data
);

  ctl_t  ctl;
  stat_t stat;

  spsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  spsr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd),
    .ctl      (ctl),
    .stat     (stat),
    .res      (res)
  );

endmodule

>>> tb/sv/stepper_phase_sequencer_ramp_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_ramp_test
// Self-checking bench for the stepper phase sequencer with speed ramp.
// ----------------------------------------------------------------------------
// Drives step ticks, ramp ticks and target updates over the command channel,
// keeps its own model of position, speed, target, period and coils, and
// compares every result transfer against the oldest predicted status.
// Covers register extremes, every drive mode including the reserved one,
// positions left beyond the wrap, random traffic with idling on both sides
// and a long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_ramp_test;
  import spsr_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RESV = 2'd3;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_PCT     = 36;
  localparam int SHOWN_FAULTS = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cmd_t               cmd = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_t               res;
  logic               wr_en = 1'b0;
  logic [REG_W-1:0]   wr_index = '0;
  logic [STEPS_W-1:0] wr_data = '0;

  // predicted block state
  logic [STEPS_W-1:0]  steps_cfg = STEPS_RESET;
  logic [MODE_W-1:0]   mode_cfg = MODE_FULL;
  int                  pos_m = 0;
  int                  speed_m = 0;
  int                  goal_m = 0;
  logic [PERIOD_W-1:0] period_m = IDLE_PERIOD;
  logic [COIL_W-1:0]   coil_m = '0;

  res_t status_due[$];
  res_t status_got;
  int   faults = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;

  always #5 clk = ~clk;

  stepper_phase_sequencer_ramp dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // ---------------------------------------------------------------- model

  function automatic int eff_steps();
    int s;
    s = int'(steps_cfg);
    if (s == 0) s = 1;
    if (s > MAX_STEPS) s = MAX_STEPS;
    return s;
  endfunction

  function automatic bit apply_speed(input int v);
    longint q;
    int     mag;
    speed_m = v;
    if (v == 0) begin
      period_m = IDLE_PERIOD;
      return 1'b0;
    end
    mag = (v < 0) ? -v : v;
    q = longint'(eff_steps()) * longint'(PERIOD_SCALE) / longint'(mag);
    if (q > longint'(PERIOD_MAX)) q = longint'(PERIOD_MAX);
    period_m = q[PERIOD_W-1:0];
    return 1'b1;
  endfunction

  function automatic void step_motor();
    int wrap;
    if (speed_m == 0) begin
      coil_m = '0;
      return;
    end
    wrap = eff_steps() * ((mode_cfg == MODE_HALF) ? 2 : 1);
    if (speed_m > 0) begin
      pos_m = pos_m + 1;
      if (pos_m >= wrap) pos_m = 0;
    end else begin
      if (pos_m == 0 || pos_m >= wrap) pos_m = wrap - 1;
      else pos_m = pos_m - 1;
    end
    case (mode_cfg)
      MODE_FULL: begin
        case (pos_m[1:0])
          2'd0: coil_m = 4'hA;
          2'd1: coil_m = 4'h6;
          2'd2: coil_m = 4'h5;
          default: coil_m = 4'h9;
        endcase
      end
      MODE_HALF: begin
        case (pos_m[2:0])
          3'd0: coil_m = 4'h9;
          3'd1: coil_m = 4'h8;
          3'd2: coil_m = 4'hA;
          3'd3: coil_m = 4'h2;
          3'd4: coil_m = 4'h6;
          3'd5: coil_m = 4'h4;
          3'd6: coil_m = 4'h5;
          default: coil_m = 4'h1;
        endcase
      end
      MODE_WAVE: begin
        case (pos_m[1:0])
          2'd0: coil_m = 4'h8;
          2'd1: coil_m = 4'h2;
          2'd2: coil_m = 4'h4;
          default: coil_m = 4'h1;
        endcase
      end
      default: ;  // reserved mode: pattern held
    endcase
  endfunction

  function automatic res_t advance_motor(input cmd_t c);
    res_t r;
    bit   rearm;
    int   tgt;
    rearm = 1'b0;
    tgt = int'($signed(c.target_speed));
    case (c.func)
      FUNC_STEP: step_motor();
      FUNC_RAMP: begin
        if (speed_m < goal_m) rearm = apply_speed(speed_m + 1);
        else if (speed_m > goal_m) rearm = apply_speed(speed_m - 1);
      end
      FUNC_TARGET: begin
        goal_m = tgt;
        if (speed_m > -FAST_LIMIT && speed_m < FAST_LIMIT) rearm = apply_speed(tgt);
      end
      default: ;
    endcase
    r.coils       = coil_m;
    r.position    = pos_m[POS_W-1:0];
    r.speed_now   = speed_m[SPEED_W-1:0];
    r.step_period = period_m;
    r.rearm       = rearm;
    return r;
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input int tgt);
    cmd_t c;
    c.func = f;
    c.target_speed = tgt[SPEED_W-1:0];
    while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    status_due.push_back(advance_motor(c));
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input int val);
    cmd_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val[STEPS_W-1:0];
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_STEPS) steps_cfg = val[STEPS_W-1:0];
    else mode_cfg = val[MODE_W-1:0];
  endtask

  task automatic set_config(input int steps, input logic [MODE_W-1:0] mode);
    write_reg(REG_STEPS, steps);
    write_reg(REG_MODE, int'(mode));
  endtask

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= SHOWN_FAULTS) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= rx_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (status_due.size() == 0) begin
        note_fault($sformatf("unexpected result transfer: coils %h pos %0d speed %0d",
                             res.coils, res.position, $signed(res.speed_now)));
      end else begin
        status_got = status_due.pop_front();
        if (res.coils !== status_got.coils || res.position !== status_got.position ||
            res.speed_now !== status_got.speed_now ||
            res.step_period !== status_got.step_period || res.rearm !== status_got.rearm)
          note_fault($sformatf({"mismatch: expected coils %h pos %0d speed %0d period %0d ",
                                "rearm %b, got coils %h pos %0d speed %0d period %0d rearm %b"},
                               status_got.coils, status_got.position,
                               $signed(status_got.speed_now), status_got.step_period,
                               status_got.rearm, res.coils, res.position,
                               $signed(res.speed_now), res.step_period, res.rearm));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("stepper_phase_sequencer_ramp_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_cmd(FUNC_STEP, 0);        // coasting at speed zero
    send_cmd(FUNC_NONE, 16'h7FFF);
    send_cmd(FUNC_RAMP, 0);        // already at target
  endtask

  task automatic test_commands();
    send_cmd(FUNC_TARGET, 3);
    send_cmd(FUNC_STEP, 0);
    send_cmd(FUNC_STEP, 0);
    send_cmd(FUNC_RAMP, 0);
    send_cmd(FUNC_TARGET, -2);
    repeat (3) send_cmd(FUNC_STEP, 0);  // back through zero to wrap-1
    send_cmd(FUNC_TARGET, 99);
    send_cmd(FUNC_TARGET, 101);
    send_cmd(FUNC_TARGET, 40);          // fast: target stored only
    send_cmd(FUNC_RAMP, 0);
    send_cmd(FUNC_NONE, -32768);
    send_cmd(FUNC_TARGET, 0);
    send_cmd(FUNC_RAMP, 0);
    send_cmd(FUNC_TARGET, 0);
    send_cmd(FUNC_STEP, 0);
  endtask

  task automatic test_register_extremes();
    set_config(0, MODE_FULL);           // zero steps behaves as one
    send_cmd(FUNC_TARGET, 5);
    send_cmd(FUNC_STEP, 0);
    set_config(8191, MODE_HALF);        // clamped to the maximum
    send_cmd(FUNC_TARGET, -5);
    send_cmd(FUNC_STEP, 0);
    set_config(4, MODE_WAVE);           // position now beyond the wrap
    send_cmd(FUNC_TARGET, 5);
    send_cmd(FUNC_STEP, 0);
    set_config(8191, MODE_HALF);
    send_cmd(FUNC_TARGET, -5);
    send_cmd(FUNC_STEP, 0);
    set_config(4, MODE_RESV);
    send_cmd(FUNC_STEP, 0);
    set_config(4096, MODE_FULL);
    send_cmd(FUNC_STEP, 0);
    send_cmd(FUNC_TARGET, 0);
  endtask

  task automatic test_random_traffic();
    int steps;
    int sel;
    int tgt;
    logic [MODE_W-1:0] mode;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(9))
        0: steps = 0;
        1: steps = 1;
        2: steps = $urandom_range(2, 4);
        3: steps = 4096;
        4: steps = $urandom_range(4097, 8191);
        5: steps = 8191;
        6: steps = $urandom_range(1, 8191);
        default: steps = $urandom_range(1, 300);
      endcase
      mode = ($urandom_range(9) == 0) ? MODE_RESV : MODE_W'($urandom_range(2));
      set_config(steps, mode);
      // one phase runs flat out on both sides
      tx_idle = (phase != 4);
      rx_idle = (phase != 4);
      for (int n = 0; n < 150; n++) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          send_cmd(FUNC_STEP, $urandom_range(16'hFFFF));
        end else if (sel < 65) begin
          send_cmd(FUNC_RAMP, $urandom_range(16'hFFFF));
        end else if (sel < 95) begin
          // full-range targets only while fast, so they are stored, not taken
          if ((speed_m >= FAST_LIMIT || speed_m <= -FAST_LIMIT) && $urandom_range(3) == 0)
            tgt = $urandom_range(16'hFFFF);
          else if ($urandom_range(7) == 0)
            tgt = ($urandom_range(1) ? 1 : -1) * $urandom_range(98, 102);
          else
            tgt = $urandom_range(300) - 150;
          send_cmd(FUNC_TARGET, tgt);
        end else begin
          send_cmd(FUNC_NONE, $urandom_range(16'hFFFF));
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_result_holdoff();
    set_config(200, MODE_HALF);
    tx_idle = 1'b0;
    hold_left <= 300;
    send_cmd(FUNC_TARGET, 20);
    repeat (6) send_cmd(FUNC_STEP, 0);
    send_cmd(FUNC_TARGET, -30);
    repeat (4) send_cmd(FUNC_STEP, 0);
    tx_idle = 1'b1;
  endtask

  task automatic test_speed_extremes();
    send_cmd(FUNC_TARGET, 0);
    while (speed_m >= FAST_LIMIT || speed_m <= -FAST_LIMIT) send_cmd(FUNC_RAMP, 0);
    set_config(4096, MODE_WAVE);
    send_cmd(FUNC_TARGET, -32768);      // magnitude one past the positive range
    send_cmd(FUNC_STEP, 0);
    send_cmd(FUNC_TARGET, 32767);       // fast: stored only
    send_cmd(FUNC_RAMP, 0);
    send_cmd(FUNC_STEP, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_commands();
    test_register_extremes();
    test_random_traffic();
    test_result_holdoff();
    test_speed_extremes();
    cmd_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("stepper_phase_sequencer_ramp_test passed");
    end else begin
      $display("stepper_phase_sequencer_ramp_test failed");
    end
    $finish;
  end

endmodule

>>> stepper_phase_sequencer_ramp.f
+incdir+hw/rtl
hw/rtl/spsr_pkg.sv
hw/rtl/spsr_dp.sv
hw/rtl/spsr_ctrl.sv
hw/rtl/stepper_phase_sequencer_ramp.sv
tb/sv/stepper_phase_sequencer_ramp_test.sv
